@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the complex fixed-point ALU.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ sv/cfpa_pkg.sv @@
// Package of the complex fixed-point ALU: widths, opcodes and payload types.
// Depends on nothing; used by complex_fixed_point_alu.
package cfpa_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_CONJ = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]                   opcode;
		logic signed [DATA_WIDTH-1:0] a_re;
		logic signed [DATA_WIDTH-1:0] a_im;
		logic signed [DATA_WIDTH-1:0] b_re;
		logic signed [DATA_WIDTH-1:0] b_im;
	} req_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] res_re;
		logic signed [DATA_WIDTH-1:0] res_im;
		logic                         overflow;
		logic                         divide_by_zero;
	} rsp_t;

endpackage

@@ sv/complex_fixed_point_alu.sv @@
// Complex fixed-point ALU: pipelined add, subtract, multiply, divide and conjugate.
// Depends on cfpa_pkg (types, widths, opcodes) and assert_macros.svh.
//
// Usage:
//   req carries one transaction: opcode and the complex operands A and B in
//   signed fixed point (FRAC_BITS fraction bits). It is taken at a rising edge
//   with req_valid high and req_stall low. rsp carries the saturated complex
//   result with overflow and divide_by_zero flags, taken at an edge with
//   rsp_valid high and rsp_stall low.
//   The pipeline has seven stages of operand prep, partial products,
//   assembly, sums and divider setup, then one restoring-division stage per
//   quotient bit, then the saturating output register. One transaction enters
//   every cycle while the result is not stalled; each divider stage resolves
//   one quotient bit for both result parts, so the divider sets the depth.
//   When the receiver stalls a valid result, the whole pipeline freezes and
//   req_stall goes high in the same cycle; nothing is lost or repeated.
//   Reset clears every stage valid bit; the pipeline comes up empty.
`include "assert_macros.svh"

module complex_fixed_point_alu #(
	parameter int FRAC_BITS = cfpa_pkg::FRAC_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  cfpa_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output cfpa_pkg::rsp_t rsp
);

	localparam int W  = cfpa_pkg::DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int H  = W / 2;
	localparam int HW = W - H;
	localparam int PW = 2 * W;
	localparam int SW = PW + 2;
	localparam int NW = PW + F;
	localparam int CW = 3 * W + F;

	// operand index: 0 a_re, 1 a_im, 2 b_re, 3 b_im
	localparam int XI [6] = '{0, 1, 0, 1, 2, 3};
	localparam int YI [6] = '{2, 3, 3, 2, 2, 3};

	localparam logic [PW-1:0] LIM  = PW'(1) << (W - 1);
	localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};

	typedef logic signed [W:0]    sx_t;
	typedef logic signed [SW-1:0] sw_t;

	typedef struct packed {
		logic [2:0]             op;
		logic [1:0]             neg;
		logic [1:0][PW-1:0]     mag;
		logic [1:0]             big;
		logic [PW-1:0]          den;
		logic [1:0][PW-1:0]     rem;
		logic [1:0][W-1:0]      nl;
		logic [1:0][W-1:0]      q;
	} dstage_t;

	logic adv;

	// stage 1
	logic                 v_s1;
	logic [2:0]           op_s1;
	logic [3:0]           neg_s1;
	logic [3:0][W-1:0]    mag_s1;
	sx_t                  sre_s1, sim_s1;
	// stage 2
	logic                 v_s2;
	logic [2:0]           op_s2;
	logic [5:0]           ps_s2;
	logic [5:0][3:0][2*HW-1:0] pp_s2;
	sx_t                  sre_s2, sim_s2;
	// stage 3
	logic                 v_s3;
	logic [2:0]           op_s3;
	logic [5:0]           ps_s3;
	logic [5:0][PW-1:0]   pm_s3;
	sx_t                  sre_s3, sim_s3;
	// stage 4
	logic                 v_s4;
	logic [2:0]           op_s4;
	sw_t                  pv_s4 [4];
	logic [PW-1:0]        den_s4;
	sx_t                  sre_s4, sim_s4;
	// stage 5
	logic                 v_s5;
	logic [2:0]           op_s5;
	sw_t                  vre_s5, vim_s5;
	logic [PW-1:0]        den_s5;
	// stage 6
	logic                 v_s6;
	logic [2:0]           op_s6;
	logic [1:0]           neg_s6;
	logic [1:0][PW-1:0]   mag_s6;
	logic [PW-1:0]        den_s6;
	// stage 7 and divider stages
	logic                 v_s7;
	dstage_t              st_s7;
	logic [W-1:0]         v_s8;
	dstage_t              div_s8 [W];
	// output
	logic                 v_s9;
	cfpa_pkg::rsp_t       out_s9;

	// next-stage values
	logic [3:0]           neg_n;
	logic [3:0][W-1:0]    mag_n;
	sx_t                  sre_n, sim_n;
	logic [5:0][3:0][2*HW-1:0] pp_n;
	logic [5:0]           ps_n;
	logic [5:0][PW-1:0]   pm_n;
	sw_t                  pv_n [4];
	sw_t                  vre_n, vim_n;
	logic [1:0]           neg6_n;
	logic [1:0][PW-1:0]   mag6_n;
	dstage_t              st7_n;
	cfpa_pkg::rsp_t       out_n;

	assign adv       = !(v_s9 && rsp_stall);
	assign req_stall = !adv;
	assign rsp_valid = v_s9;
	assign rsp       = out_s9;

	function automatic dstage_t div_step(dstage_t s);
		dstage_t       r;
		logic [PW:0]   t;
		logic [PW:0]   d;
		logic          ge;
		r = s;
		d = {1'b0, s.den};
		for (int i = 0; i < 2; i++) begin
			t  = {s.rem[i], s.nl[i][W-1]};
			ge = (t >= d);
			r.rem[i] = ge ? PW'(t - d) : PW'(t);
			r.q[i]   = {s.q[i][W-2:0], ge};
			r.nl[i]  = s.nl[i] << 1;
		end
		return r;
	endfunction

	// stage 1: magnitudes, and the results that need no product
	always_comb begin
		logic [3:0][W-1:0] raw;
		raw = {req.b_im, req.b_re, req.a_im, req.a_re};
		for (int i = 0; i < 4; i++) begin
			neg_n[i] = raw[i][W-1];
			mag_n[i] = raw[i][W-1] ? (~raw[i] + 1'b1) : raw[i];
		end
		unique case (req.opcode)
			cfpa_pkg::OP_ADD: begin
				sre_n = sx_t'(req.a_re) + sx_t'(req.b_re);
				sim_n = sx_t'(req.a_im) + sx_t'(req.b_im);
			end
			cfpa_pkg::OP_SUB: begin
				sre_n = sx_t'(req.a_re) - sx_t'(req.b_re);
				sim_n = sx_t'(req.a_im) - sx_t'(req.b_im);
			end
			cfpa_pkg::OP_CONJ: begin
				sre_n = sx_t'(req.a_re);
				sim_n = -sx_t'(req.a_im);
			end
			default: begin
				sre_n = '0;
				sim_n = '0;
			end
		endcase
	end

	// stage 2: half-width partial products of the six magnitude products
	always_comb begin
		logic [HW-1:0] xh, xl, yh, yl;
		for (int p = 0; p < 6; p++) begin
			xh = HW'(mag_s1[XI[p]][W-1:H]);
			xl = HW'(mag_s1[XI[p]][H-1:0]);
			yh = HW'(mag_s1[YI[p]][W-1:H]);
			yl = HW'(mag_s1[YI[p]][H-1:0]);
			pp_n[p][0] = (2*HW)'(xh * yh);
			pp_n[p][1] = (2*HW)'(xh * yl);
			pp_n[p][2] = (2*HW)'(xl * yh);
			pp_n[p][3] = (2*HW)'(xl * yl);
			ps_n[p]    = neg_s1[XI[p]] ^ neg_s1[YI[p]];
		end
	end

	// stage 3: assemble the full products
	always_comb begin
		for (int p = 0; p < 6; p++) begin
			pm_n[p] = (PW'(pp_s2[p][0]) << (2 * H)) + (PW'(pp_s2[p][1]) << H)
				+ (PW'(pp_s2[p][2]) << H) + PW'(pp_s2[p][3]);
		end
	end

	// stage 4: signed products
	always_comb begin
		sw_t m;
		for (int p = 0; p < 4; p++) begin
			m = sw_t'({2'b00, pm_s3[p]});
			pv_n[p] = ps_s3[p] ? -m : m;
		end
	end

	// stage 5: combine products per opcode
	always_comb begin
		unique case (op_s4)
			cfpa_pkg::OP_MUL: begin
				vre_n = pv_s4[0] - pv_s4[1];
				vim_n = pv_s4[2] + pv_s4[3];
			end
			cfpa_pkg::OP_DIV: begin
				vre_n = pv_s4[0] + pv_s4[1];
				vim_n = pv_s4[3] - pv_s4[2];
			end
			default: begin
				vre_n = sw_t'(sre_s4);
				vim_n = sw_t'(sim_s4);
			end
		endcase
	end

	// stage 6: sign and magnitude; scale products back for multiply
	always_comb begin
		sw_t v;
		sw_t t;
		for (int i = 0; i < 2; i++) begin
			v = (i == 0) ? vre_s5 : vim_s5;
			neg6_n[i] = v[SW-1];
			t = v[SW-1] ? -v : v;
			mag6_n[i] = (op_s5 == cfpa_pkg::OP_MUL) ? (t[PW-1:0] >> F) : t[PW-1:0];
		end
	end

	// stage 7: divider setup; flag quotients that cannot fit before dividing
	always_comb begin
		logic [NW-1:0] num;
		st7_n.op  = op_s6;
		st7_n.neg = neg_s6;
		st7_n.mag = mag_s6;
		st7_n.den = den_s6;
		st7_n.q   = '0;
		for (int i = 0; i < 2; i++) begin
			num = {mag_s6[i], {F{1'b0}}};
			st7_n.big[i] = CW'(num) >= CW'({den_s6, {W{1'b0}}});
			st7_n.rem[i] = PW'(num[NW-1:W]);
			st7_n.nl[i]  = num[W-1:0];
		end
	end

	// output: saturate each part, or clear the result on a divide by zero
	always_comb begin
		dstage_t       s;
		logic          is_div;
		logic [PW-1:0] m;
		logic [PW-1:0] nm;
		logic          ovf;
		logic          big;
		logic [1:0][W-1:0] val;
		s      = div_s8[W-1];
		is_div = (s.op == cfpa_pkg::OP_DIV);
		ovf    = 1'b0;
		for (int i = 0; i < 2; i++) begin
			m   = is_div ? PW'(s.q[i]) : s.mag[i];
			big = is_div && s.big[i];
			nm  = -m;
			if (big || (!s.neg[i] && m >= LIM) || (s.neg[i] && m > LIM)) begin
				ovf    = 1'b1;
				val[i] = s.neg[i] ? MINV : MAXV;
			end else begin
				val[i] = s.neg[i] ? nm[W-1:0] : m[W-1:0];
			end
		end
		if (is_div && s.den == '0) begin
			out_n.res_re         = '0;
			out_n.res_im         = '0;
			out_n.overflow       = 1'b0;
			out_n.divide_by_zero = 1'b1;
		end else begin
			out_n.res_re         = val[0];
			out_n.res_im         = val[1];
			out_n.overflow       = ovf;
			out_n.divide_by_zero = 1'b0;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= '0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= {v_s8[W-2:0], v_s7};
			v_s9 <= v_s8[W-1];
		end
	end

	// payload: advance as one, hold while the result is stalled
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= req.opcode;
			neg_s1 <= neg_n;
			mag_s1 <= mag_n;
			sre_s1 <= sre_n;
			sim_s1 <= sim_n;

			op_s2  <= op_s1;
			pp_s2  <= pp_n;
			ps_s2  <= ps_n;
			sre_s2 <= sre_s1;
			sim_s2 <= sim_s1;

			op_s3  <= op_s2;
			pm_s3  <= pm_n;
			ps_s3  <= ps_s2;
			sre_s3 <= sre_s2;
			sim_s3 <= sim_s2;

			op_s4  <= op_s3;
			for (int p = 0; p < 4; p++) begin
				pv_s4[p] <= pv_n[p];
			end
			den_s4 <= pm_s3[4] + pm_s3[5];
			sre_s4 <= sre_s3;
			sim_s4 <= sim_s3;

			op_s5  <= op_s4;
			vre_s5 <= vre_n;
			vim_s5 <= vim_n;
			den_s5 <= den_s4;

			op_s6  <= op_s5;
			neg_s6 <= neg6_n;
			mag_s6 <= mag6_n;
			den_s6 <= den_s5;

			st_s7  <= st7_n;

			div_s8[0] <= div_step(st_s7);
			for (int k = 1; k < W; k++) begin
				div_s8[k] <= div_step(div_s8[k-1]);
			end

			out_s9 <= out_n;
		end
	end

	`ASSERT_CLK(a_stall_follows_output, req_stall == (rsp_valid && rsp_stall), "input stall does not follow a stalled result")
	`ASSERT_CLK(a_dbz_gives_zero, (rsp_valid && rsp.divide_by_zero) |-> (rsp.res_re == '0 && rsp.res_im == '0 && !rsp.overflow), "divide by zero result not cleared")
	`ASSERT_CLK(a_ovf_saturates, (rsp_valid && rsp.overflow) |-> (rsp.res_re == MAXV || rsp.res_re == MINV || rsp.res_im == MAXV || rsp.res_im == MINV), "overflow flagged without a saturated part")

endmodule
